@@ design/cgcb_pkg.sv @@
// Package for the clipped glyph coverage blit: limits, register codes and the
// structs passed between the pipeline modules. No dependencies.
`default_nettype none

package cgcb_pkg;

    localparam int MAX_FRAME = 4096;
    localparam int MAX_GLYPH = 256;

    localparam logic [23:0] BG_RESET = 24'h000000;
    localparam logic [23:0] FG_RESET = 24'h00FF00;
    localparam logic [12:0] FW_RESET = 13'd1920;
    localparam logic [12:0] FH_RESET = 13'd1080;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        REG_BACKGROUND = 2'd0,
        REG_FOREGROUND = 2'd1,
        REG_FRAME_W    = 2'd2,
        REG_FRAME_H    = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] background;
        logic [23:0] foreground;
        logic [12:0] frame_width;
        logic [12:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [12:0] origin_x;
        logic [12:0] origin_y;
        logic [8:0]  bearing_left;
        logic [8:0]  bearing_top;
        logic [8:0]  glyph_width;
        logic [8:0]  glyph_height;
        logic [7:0]  glyph_col;
        logic [7:0]  glyph_row;
        logic [7:0]  coverage;
    } in_item_t;

    typedef struct packed {
        logic             clear;
        logic             visible;
        logic             hit;
        logic [11:0]      rect_x;
        logic [11:0]      rect_y;
        logic [12:0]      rect_w;
        logic [12:0]      rect_h;
        logic [11:0]      px;
        logic [24:0]      addr_prod;
        logic [2:0][17:0] prod;
    } mid_t;

    typedef struct packed {
        logic [11:0] x;
        logic [11:0] y;
        logic [12:0] w;
        logic [12:0] h;
    } ink_t;

    typedef struct packed {
        logic        write;
        logic [23:0] addr;
        logic [31:0] colour;
    } pix_t;

    typedef struct packed {
        pix_t pix;
        ink_t ink;
    } out_item_t;

endpackage

`default_nettype wire

@@ design/cgcb_regs.sv @@
// APB configuration registers for the glyph blit.
// Depends on cgcb_pkg for the register codes and reset values.
`default_nettype none

module cgcb_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output cgcb_pkg::cfg_t     cfg
);

    cgcb_pkg::cfg_t     cfg_reg;
    cgcb_pkg::cfg_t     cfg_next;
    cgcb_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = cgcb_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                cgcb_pkg::REG_BACKGROUND: cfg_next.background   = pwdata[23:0];
                cgcb_pkg::REG_FOREGROUND: cfg_next.foreground   = pwdata[23:0];
                cgcb_pkg::REG_FRAME_W:    cfg_next.frame_width  = pwdata[12:0];
                cgcb_pkg::REG_FRAME_H:    cfg_next.frame_height = pwdata[12:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            cgcb_pkg::REG_BACKGROUND: prdata = {8'd0, cfg_reg.background};
            cgcb_pkg::REG_FOREGROUND: prdata = {8'd0, cfg_reg.foreground};
            cgcb_pkg::REG_FRAME_W:    prdata = {19'd0, cfg_reg.frame_width};
            cgcb_pkg::REG_FRAME_H:    prdata = {19'd0, cfg_reg.frame_height};
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.background   <= cgcb_pkg::BG_RESET;
            cfg_reg.foreground   <= cgcb_pkg::FG_RESET;
            cfg_reg.frame_width  <= cgcb_pkg::FW_RESET;
            cfg_reg.frame_height <= cgcb_pkg::FH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ design/cgcb_geom.sv @@
// First stage: glyph placement, clipping against the frame, pixel hit test,
// row-times-pitch product and per-channel coverage products. Uses cgcb_pkg.
`default_nettype none

module cgcb_geom (
    input  cgcb_pkg::in_item_t item,
    input  cgcb_pkg::cfg_t     cfg,
    output cgcb_pkg::mid_t     mid
);

    logic [12:0]        bw;
    logic [12:0]        bh;
    logic [8:0]         gw;
    logic [8:0]         gh;
    logic signed [15:0] x0, y0;
    logic signed [15:0] gw_s, gh_s, bw_s, bh_s, col_s, row_s;
    logic signed [15:0] rs, re, cs, ce;
    logic signed [15:0] rx_s, ry_s, rw_s, rh_s, px_s, py_s;
    logic               in_rect;
    logic [8:0]         diff [3];

    always_comb begin
        bw = (cfg.frame_width  > 13'(cgcb_pkg::MAX_FRAME)) ?
             13'(cgcb_pkg::MAX_FRAME) : cfg.frame_width;
        bh = (cfg.frame_height > 13'(cgcb_pkg::MAX_FRAME)) ?
             13'(cgcb_pkg::MAX_FRAME) : cfg.frame_height;
        gw = (item.glyph_width  > 9'(cgcb_pkg::MAX_GLYPH)) ?
             9'(cgcb_pkg::MAX_GLYPH) : item.glyph_width;
        gh = (item.glyph_height > 9'(cgcb_pkg::MAX_GLYPH)) ?
             9'(cgcb_pkg::MAX_GLYPH) : item.glyph_height;

        x0 = $signed({{3{item.origin_x[12]}}, item.origin_x})
           + $signed({{7{item.bearing_left[8]}}, item.bearing_left});
        y0 = $signed({{3{item.origin_y[12]}}, item.origin_y})
           - $signed({{7{item.bearing_top[8]}}, item.bearing_top});

        gw_s  = $signed({7'd0, gw});
        gh_s  = $signed({7'd0, gh});
        bw_s  = $signed({3'd0, bw});
        bh_s  = $signed({3'd0, bh});
        col_s = $signed({8'd0, item.glyph_col});
        row_s = $signed({8'd0, item.glyph_row});

        rs = (y0 < 16'sd0) ? -y0 : 16'sd0;
        re = (y0 + gh_s > bh_s) ? bh_s - y0 : gh_s;
        cs = (x0 < 16'sd0) ? -x0 : 16'sd0;
        ce = (x0 + gw_s > bw_s) ? bw_s - x0 : gw_s;

        rx_s = x0 + cs;
        ry_s = y0 + rs;
        rw_s = ce - cs;
        rh_s = re - rs;
        px_s = x0 + col_s;
        py_s = y0 + row_s;

        in_rect = (row_s >= rs) && (row_s < re) && (col_s >= cs) && (col_s < ce);

        mid.clear     = !item.action;
        mid.visible   = item.action && (rs < re) && (cs < ce);
        mid.hit       = mid.visible && in_rect && (item.coverage != 8'd0);
        mid.rect_x    = rx_s[11:0];
        mid.rect_y    = ry_s[11:0];
        mid.rect_w    = rw_s[12:0];
        mid.rect_h    = rh_s[12:0];
        mid.px        = px_s[11:0];
        mid.addr_prod = {13'd0, py_s[11:0]} * {12'd0, bw};

        for (int i = 0; i < 3; i++) begin
            diff[i] = {1'b0, cfg.foreground[8*i +: 8]} - {1'b0, cfg.background[8*i +: 8]};
            mid.prod[i] = {{9{diff[i][8]}}, diff[i]} * {10'd0, item.coverage};
        end
    end

endmodule

`default_nettype wire

@@ design/cgcb_finish.sv @@
// Second stage pixel path: divide-by-255 of the coverage products with
// truncation toward zero, blended colour and frame address. Uses cgcb_pkg.
`default_nettype none

module cgcb_finish (
    input  cgcb_pkg::mid_t mid,
    input  cgcb_pkg::cfg_t cfg,
    output cgcb_pkg::pix_t pix
);

    logic        neg [3];
    logic [17:0] mag [3];
    logic [16:0] acc [3];
    logic [7:0]  quo [3];
    logic [7:0]  chan [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg[i]  = mid.prod[i][17];
            mag[i]  = neg[i] ? (18'd0 - mid.prod[i]) : mid.prod[i];
            // exact x/255 for x below 65280
            acc[i]  = {1'b0, mag[i][15:0]} + {9'd0, mag[i][15:8]} + 17'd1;
            quo[i]  = acc[i][15:8];
            chan[i] = cfg.background[8*i +: 8] + (neg[i] ? (8'd0 - quo[i]) : quo[i]);
        end

        pix.write = mid.hit;
        if (mid.hit) begin
            pix.addr   = 24'(mid.addr_prod + {13'd0, mid.px});
            pix.colour = {cgcb_pkg::ALPHA_OPAQUE, chan[2], chan[1], chan[0]};
        end else begin
            pix.addr   = 24'd0;
            pix.colour = 32'd0;
        end
    end

endmodule

`default_nettype wire

@@ design/cgcb_ink.sv @@
// Running ink rectangle: clear, hold for an invisible glyph, first load and
// bounding-box union of the clipped glyph rectangle. Uses cgcb_pkg.
`default_nettype none

module cgcb_ink (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      advance,
    input  cgcb_pkg::mid_t mid,
    output cgcb_pkg::ink_t ink_next
);

    cgcb_pkg::ink_t ink_reg;
    logic [11:0]    x1, y1;
    logic [13:0]    ix2, iy2, rx2, ry2, x2, y2;

    always_comb begin
        x1  = (ink_reg.x < mid.rect_x) ? ink_reg.x : mid.rect_x;
        y1  = (ink_reg.y < mid.rect_y) ? ink_reg.y : mid.rect_y;
        ix2 = {2'd0, ink_reg.x} + {1'd0, ink_reg.w};
        iy2 = {2'd0, ink_reg.y} + {1'd0, ink_reg.h};
        rx2 = {2'd0, mid.rect_x} + {1'd0, mid.rect_w};
        ry2 = {2'd0, mid.rect_y} + {1'd0, mid.rect_h};
        x2  = (ix2 > rx2) ? ix2 : rx2;
        y2  = (iy2 > ry2) ? iy2 : ry2;

        if (mid.clear) begin
            ink_next = '0;
        end else if (!mid.visible) begin
            ink_next = ink_reg;
        end else if (ink_reg.w == 13'd0) begin
            ink_next.x = mid.rect_x;
            ink_next.y = mid.rect_y;
            ink_next.w = mid.rect_w;
            ink_next.h = mid.rect_h;
        end else begin
            ink_next.x = x1;
            ink_next.y = y1;
            ink_next.w = 13'(x2 - {2'd0, x1});
            ink_next.h = 13'(y2 - {2'd0, y1});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ink_reg <= '0;
        end else if (advance) begin
            ink_reg <= ink_next;
        end
    end

endmodule

`default_nettype wire

@@ design/clipped_glyph_coverage_blit_top.sv @@
// Top level of the clipped glyph coverage blit: stream ports, pipeline
// registers and handshake. Uses cgcb_pkg, cgcb_regs, cgcb_geom, cgcb_finish, cgcb_ink.
//
// Usage: each item on s_ carries one glyph coverage pixel with its glyph's
// placement; s_tuser is the action (0 clears the ink rectangle, 1 draws).
// Each item yields exactly one result on m_: m_tuser says whether the pixel is
// written, m_tdata holds address, ARGB colour and the ink rectangle after it.
// Three register stages (input, geometry/products, result) pass each item on
// in that order. One item per clock is sustained while m_tready stays high;
// the ink rectangle is updated in the second stage, so back-to-back items see
// each other's union with no gap.
// When m_tready is low the result register holds; items are still accepted
// until the input and middle stages are full, then s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline, clears the ink
// rectangle and loads the register reset values. Configuration must be
// written over APB only while no item is in flight; the block does not enforce it.
`default_nettype none

module clipped_glyph_coverage_blit_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, bearing_left, bearing_top, glyph_width, glyph_height,
    // glyph_col, glyph_row, coverage, zero pad
    input  wire logic [87:0]  s_tdata,
    // action
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // pixel_address, pixel_colour, ink_left, ink_top, ink_span_x, ink_span_y, zero pad
    output logic [111:0]      m_tdata,
    // write_pixel
    output logic              m_tuser
);

    cgcb_pkg::cfg_t      cfg;
    cgcb_pkg::in_item_t  in_item;
    cgcb_pkg::in_item_t  in_item_reg;
    cgcb_pkg::mid_t      mid_next;
    cgcb_pkg::mid_t      mid_reg;
    cgcb_pkg::pix_t      pix;
    cgcb_pkg::ink_t      ink_next;
    cgcb_pkg::out_item_t out_next;
    cgcb_pkg::out_item_t out_reg;

    logic in_vld_reg, in_vld_next;
    logic mid_vld_reg, mid_vld_next;
    logic out_vld_reg, out_vld_next;
    logic accept, adv1, adv2;

    cgcb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        in_item.action       = s_tuser;
        in_item.origin_x     = s_tdata[12:0];
        in_item.origin_y     = s_tdata[25:13];
        in_item.bearing_left = s_tdata[34:26];
        in_item.bearing_top  = s_tdata[43:35];
        in_item.glyph_width  = s_tdata[52:44];
        in_item.glyph_height = s_tdata[61:53];
        in_item.glyph_col    = s_tdata[69:62];
        in_item.glyph_row    = s_tdata[77:70];
        in_item.coverage     = s_tdata[85:78];
    end

    cgcb_geom u_geom (
        .item (in_item_reg),
        .cfg  (cfg),
        .mid  (mid_next)
    );

    cgcb_finish u_finish (
        .mid (mid_reg),
        .cfg (cfg),
        .pix (pix)
    );

    cgcb_ink u_ink (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (adv2),
        .mid      (mid_reg),
        .ink_next (ink_next)
    );

    always_comb begin
        adv2     = mid_vld_reg && (!out_vld_reg || m_tready);
        adv1     = in_vld_reg && (!mid_vld_reg || adv2);
        s_tready = !in_vld_reg || adv1;
        accept   = s_tvalid && s_tready;

        in_vld_next  = accept ? 1'b1 : (adv1 ? 1'b0 : in_vld_reg);
        mid_vld_next = adv1 ? 1'b1 : (adv2 ? 1'b0 : mid_vld_reg);
        out_vld_next = adv2 ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);

        out_next.pix = pix;
        out_next.ink = ink_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            mid_vld_reg <= mid_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= in_item;
        end
        if (adv1) begin
            mid_reg <= mid_next;
        end
        if (adv2) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.pix.write;
    assign m_tdata  = {6'd0, out_reg.ink.h, out_reg.ink.w, out_reg.ink.y, out_reg.ink.x,
                       out_reg.pix.colour, out_reg.pix.addr};

`ifndef NO_ASSERTIONS
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[55:0] == 56'd0))
        else $error("result without write carries address or colour");

    a_write_opaque: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[55:48] == cgcb_pkg::ALPHA_OPAQUE))
        else $error("written pixel is not opaque");

    a_empty_ink: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[92:80] == 13'd0)) |->
        ((m_tdata[79:56] == 24'd0) && (m_tdata[105:93] == 13'd0)))
        else $error("empty ink rectangle has nonzero corner or height");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && mid_vld_reg && m_tvalid && !m_tready))
        else $error("input stalled while pipeline has room");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking bench for clipped_glyph_coverage_blit_top: directed and random
// glyph pixel items on s_, results on m_ checked against an in-bench predictor.
// Depends on cgcb_pkg and the RTL under design/.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLDOFF_CYCLES = 300;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         m_tuser;

    clipped_glyph_coverage_blit_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // register shadow and ink rectangle of the predictor
    logic [23:0] bg_shadow = cgcb_pkg::BG_RESET;
    logic [23:0] fg_shadow = cgcb_pkg::FG_RESET;
    logic [12:0] fw_shadow = cgcb_pkg::FW_RESET;
    logic [12:0] fh_shadow = cgcb_pkg::FH_RESET;
    logic [11:0] ink_x = '0;
    logic [11:0] ink_y = '0;
    logic [12:0] ink_w = '0;
    logic [12:0] ink_h = '0;

    cgcb_pkg::in_item_t  pending_pixels[$];
    cgcb_pkg::out_item_t expected_pixels[$];

    int tx_idle_pct = 9;
    int rx_idle_pct = 68;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int err_count = 0;
    int items_in = 0;
    int results_out = 0;
    int writes_seen = 0;
    int clears_seen = 0;
    int backpressure_cycles = 0;
    int cycle_count = 0;

    function automatic void enqueue_item(cgcb_pkg::in_item_t it);
        pending_pixels = {pending_pixels, it};
    endfunction

    function automatic logic [7:0] mix_channel(logic [7:0] b, logic [7:0] f, int cov);
        int v;
        v = int'(b) + ((int'(f) - int'(b)) * cov) / 255;
        return v[7:0];
    endfunction

    function automatic void ink_merge(int x, int y, int w, int h);
        int x1, y1, x2, y2;
        if (w <= 0 || h <= 0) return;
        if (ink_w == 0) begin
            ink_x = 12'(x);
            ink_y = 12'(y);
            ink_w = 13'(w);
            ink_h = 13'(h);
            return;
        end
        x1 = int'(ink_x) < x ? int'(ink_x) : x;
        y1 = int'(ink_y) < y ? int'(ink_y) : y;
        x2 = int'(ink_x) + int'(ink_w) > x + w ? int'(ink_x) + int'(ink_w) : x + w;
        y2 = int'(ink_y) + int'(ink_h) > y + h ? int'(ink_y) + int'(ink_h) : y + h;
        ink_x = 12'(x1);
        ink_y = 12'(y1);
        ink_w = 13'(x2 - x1);
        ink_h = 13'(y2 - y1);
    endfunction

    function automatic cgcb_pkg::out_item_t blit_predict(cgcb_pkg::in_item_t it);
        cgcb_pkg::out_item_t r;
        int ox, oy, bl, bt, gw, gh, col, row, cov, bw, bh, x0, y0, rs, re, cs, ce;
        r = '0;
        if (!it.action) begin
            ink_x = '0;
            ink_y = '0;
            ink_w = '0;
            ink_h = '0;
        end else begin
            ox = $signed(it.origin_x);
            oy = $signed(it.origin_y);
            bl = $signed(it.bearing_left);
            bt = $signed(it.bearing_top);
            gw = it.glyph_width > cgcb_pkg::MAX_GLYPH ? cgcb_pkg::MAX_GLYPH
                                                      : int'(it.glyph_width);
            gh = it.glyph_height > cgcb_pkg::MAX_GLYPH ? cgcb_pkg::MAX_GLYPH
                                                       : int'(it.glyph_height);
            col = it.glyph_col;
            row = it.glyph_row;
            cov = it.coverage;
            bw = fw_shadow > cgcb_pkg::MAX_FRAME ? cgcb_pkg::MAX_FRAME : int'(fw_shadow);
            bh = fh_shadow > cgcb_pkg::MAX_FRAME ? cgcb_pkg::MAX_FRAME : int'(fh_shadow);
            x0 = ox + bl;
            y0 = oy - bt;
            rs = 0;
            re = gh;
            if (y0 < 0) rs = -y0;
            if (y0 + gh > bh) re = bh - y0;
            cs = 0;
            ce = gw;
            if (x0 < 0) cs = -x0;
            if (x0 + gw > bw) ce = bw - x0;
            if (rs < re && cs < ce) begin
                ink_merge(x0 + cs, y0 + rs, ce - cs, re - rs);
                if (row >= rs && row < re && col >= cs && col < ce && cov != 0) begin
                    r.pix.write = 1'b1;
                    r.pix.addr = 24'((y0 + row) * bw + x0 + col);
                    r.pix.colour = {cgcb_pkg::ALPHA_OPAQUE,
                                    mix_channel(bg_shadow[23:16], fg_shadow[23:16], cov),
                                    mix_channel(bg_shadow[15:8], fg_shadow[15:8], cov),
                                    mix_channel(bg_shadow[7:0], fg_shadow[7:0], cov)};
                end
            end
        end
        r.ink.x = ink_x;
        r.ink.y = ink_y;
        r.ink.w = ink_w;
        r.ink.h = ink_h;
        return r;
    endfunction

    function automatic cgcb_pkg::in_item_t mk_pixel(bit act, int ox, int oy, int bl, int bt,
                                                    int gw, int gh, int col, int row,
                                                    int cov);
        cgcb_pkg::in_item_t it;
        it.action = act;
        it.origin_x = 13'(ox);
        it.origin_y = 13'(oy);
        it.bearing_left = 9'(bl);
        it.bearing_top = 9'(bt);
        it.glyph_width = 9'(gw);
        it.glyph_height = 9'(gh);
        it.glyph_col = 8'(col);
        it.glyph_row = 8'(row);
        it.coverage = 8'(cov);
        return it;
    endfunction

    // mostly small glyphs, some full size, a few oversized
    function automatic int pick_span();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(0, 24);
        if (r < 95) return $urandom_range(0, 256);
        return $urandom_range(257, 511);
    endfunction

    function automatic int pick_index(int span);
        if (span == 0 || $urandom_range(9) == 0) return $urandom_range(0, 255);
        return $urandom_range(0, (span > 256 ? 256 : span) - 1);
    endfunction

    task automatic queue_glyph_burst();
        logic [95:0] raw;
        cgcb_pkg::in_item_t it;
        int sel, fw_eff, fh_eff, ox, oy, bl, bt, gw, gh, n, cov, r;
        sel = $urandom_range(99);
        if (sel < 13) begin
            raw = {$urandom, $urandom, $urandom};
            it = raw[$bits(cgcb_pkg::in_item_t)-1:0];
            if (sel >= 8) it.action = 1'b0;
            enqueue_item(it);
            return;
        end
        fw_eff = fw_shadow > cgcb_pkg::MAX_FRAME ? cgcb_pkg::MAX_FRAME : int'(fw_shadow);
        fh_eff = fh_shadow > cgcb_pkg::MAX_FRAME ? cgcb_pkg::MAX_FRAME : int'(fh_shadow);
        ox = $urandom_range(0, fw_eff + 64) - 32;
        oy = $urandom_range(0, fh_eff + 64) - 32;
        if ($urandom_range(9) == 0) ox = $urandom_range(0, 8191) - 4096;
        if ($urandom_range(9) == 0) oy = $urandom_range(0, 8191) - 4096;
        bl = $urandom_range(0, 24) - 4;
        bt = $urandom_range(0, 40) - 4;
        if ($urandom_range(9) == 0) bl = $urandom_range(0, 511) - 256;
        if ($urandom_range(9) == 0) bt = $urandom_range(0, 511) - 256;
        gw = pick_span();
        gh = pick_span();
        n = $urandom_range(3, 12);
        repeat (n) begin
            r = $urandom_range(99);
            cov = r < 20 ? 0 : (r < 40 ? 255 : $urandom_range(1, 254));
            enqueue_item(mk_pixel(1'b1, ox, oy, bl, bt, gw, gh,
                                  pick_index(gw), pick_index(gh), cov));
        end
    endtask

    task automatic apb_write(cgcb_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            cgcb_pkg::REG_BACKGROUND: bg_shadow = val[23:0];
            cgcb_pkg::REG_FOREGROUND: fg_shadow = val[23:0];
            cgcb_pkg::REG_FRAME_W:    fw_shadow = val[12:0];
            cgcb_pkg::REG_FRAME_H:    fh_shadow = val[12:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [23:0] bg, logic [23:0] fg, logic [12:0] fw, logic [12:0] fh);
        apb_write(cgcb_pkg::REG_BACKGROUND, {8'h00, bg});
        apb_write(cgcb_pkg::REG_FOREGROUND, {8'h00, fg});
        apb_write(cgcb_pkg::REG_FRAME_W, {19'h0, fw});
        apb_write(cgcb_pkg::REG_FRAME_H, {19'h0, fh});
    endtask

    task automatic drain_pipeline();
        while (pending_pixels.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic run_bursts(int count);
        int target;
        target = pending_pixels.size() + count;
        while (pending_pixels.size() < target) queue_glyph_burst();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                cgcb_pkg::in_item_t it;
                it = pending_pixels.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= it.action;
                s_tdata <= {2'b00, it.coverage, it.glyph_row, it.glyph_col, it.glyph_height,
                            it.glyph_width, it.bearing_top, it.bearing_left, it.origin_y,
                            it.origin_x};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // accepted items feed the predictor
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            cgcb_pkg::in_item_t it;
            it.action = s_tuser;
            it.origin_x = s_tdata[12:0];
            it.origin_y = s_tdata[25:13];
            it.bearing_left = s_tdata[34:26];
            it.bearing_top = s_tdata[43:35];
            it.glyph_width = s_tdata[52:44];
            it.glyph_height = s_tdata[61:53];
            it.glyph_col = s_tdata[69:62];
            it.glyph_row = s_tdata[77:70];
            it.coverage = s_tdata[85:78];
            expected_pixels = {expected_pixels, blit_predict(it)};
            items_in++;
            if (!it.action) clears_seen++;
        end
        if (aresetn && s_tvalid && !s_tready) backpressure_cycles++;
    end

    // receiver, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            cgcb_pkg::out_item_t got, want;
            got.pix.write = m_tuser;
            got.pix.addr = m_tdata[23:0];
            got.pix.colour = m_tdata[55:24];
            got.ink.x = m_tdata[67:56];
            got.ink.y = m_tdata[79:68];
            got.ink.w = m_tdata[92:80];
            got.ink.h = m_tdata[105:93];
            results_out++;
            if (got.pix.write) writes_seen++;
            if (expected_pixels.size() == 0) begin
                err_count++;
                $display("%0t: unexpected result wr=%0b addr=%h col=%h ink=%0d,%0d %0dx%0d",
                         $time, got.pix.write, got.pix.addr, got.pix.colour,
                         got.ink.x, got.ink.y, got.ink.w, got.ink.h);
            end else begin
                want = expected_pixels.pop_front();
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch exp wr=%0b addr=%h col=%h ink=%0d,%0d %0dx%0d",
                             $time, want.pix.write, want.pix.addr, want.pix.colour,
                             want.ink.x, want.ink.y, want.ink.w, want.ink.h);
                    $display("%0t:          got wr=%0b addr=%h col=%h ink=%0d,%0d %0dx%0d",
                             $time, got.pix.write, got.pix.addr, got.pix.colour,
                             got.ink.x, got.ink.y, got.ink.w, got.ink.h);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values, directed corners first
        enqueue_item(mk_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        enqueue_item(mk_pixel(1, 0, 0, 0, 0, 8, 8, 0, 0, 255));
        enqueue_item(mk_pixel(1, 0, 0, 0, 0, 8, 8, 3, 4, 0));
        enqueue_item(mk_pixel(1, 0, 0, 0, 0, 8, 8, 8, 2, 90));
        enqueue_item(mk_pixel(1, 0, 0, 0, 0, 8, 8, 1, 8, 90));
        enqueue_item(mk_pixel(1, -4096, 20, -256, 0, 40, 40, 1, 1, 255));
        enqueue_item(mk_pixel(1, 4095, 20, 255, 0, 40, 40, 1, 1, 255));
        enqueue_item(mk_pixel(1, 20, -4096, 0, 255, 40, 40, 1, 1, 255));
        enqueue_item(mk_pixel(1, 20, 4095, 0, -256, 40, 40, 1, 1, 255));
        enqueue_item(mk_pixel(1, 1900, 1070, 0, 0, 256, 256, 10, 5, 128));
        enqueue_item(mk_pixel(1, -5, 10, 0, 20, 30, 30, 4, 12, 200));
        enqueue_item(mk_pixel(1, -5, 10, 0, 20, 30, 30, 5, 10, 200));
        enqueue_item(mk_pixel(1, 50, 50, 0, 0, 0, 12, 0, 0, 255));
        enqueue_item(mk_pixel(1, 50, 50, 0, 0, 12, 0, 0, 0, 255));
        enqueue_item(mk_pixel(1, 100, 300, 0, 0, 511, 300, 255, 255, 1));
        enqueue_item(mk_pixel(0, 4095, -4096, 255, -256, 511, 511, 255, 255, 255));
        enqueue_item(mk_pixel(1, 100, 300, 0, 0, 256, 256, 255, 255, 200));
        enqueue_item(mk_pixel(1, 300, 300, -256, 255, 16, 16, 15, 15, 255));
        enqueue_item(mk_pixel(1, 300, 300, 255, -256, 16, 16, 0, 0, 17));
        enqueue_item(mk_pixel(1, 1919, 1079, 0, 0, 1, 1, 0, 0, 254));
        run_bursts(250);
        drain_pipeline();

        set_frame(24'hFFFFFF, 24'h000000, 13'd4096, 13'd4096);
        run_bursts(250);
        drain_pipeline();

        tx_idle_pct = 68;
        rx_idle_pct = 9;
        set_frame(24'($urandom), 24'($urandom), 13'd8191, 13'd8191);
        run_bursts(250);
        drain_pipeline();

        set_frame(24'($urandom), 24'($urandom), 13'd1, 13'd1);
        run_bursts(250);
        drain_pipeline();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_frame(24'($urandom), 24'($urandom), 13'd0, 13'd0);
        run_bursts(150);
        drain_pipeline();

        set_frame(24'($urandom), 24'($urandom), 13'd640, 13'd480);
        hold_arm = 1'b1;
        run_bursts(250);
        drain_pipeline();

        if (expected_pixels.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, expected_pixels.size());
        end
        $display("%0d items in, %0d results checked: %0d pixel writes, %0d clears",
                 items_in, results_out, writes_seen, clears_seen);
        $display("six register settings incl. saturated and zero frame; %0d stalled input cycles",
                 backpressure_cycles);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
